@@ sv/nfri_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfri_pkg: shared types and constants for the NAND flash read interface
// Transaction structs, command codes, register offsets and error codes.
// ----------------------------------------------------------------------------
package nfri_pkg;

  localparam int unsigned DEF_PAGE_DATA_BYTES  = 512;
  localparam int unsigned DEF_PAGE_SPARE_BYTES = 16;
  localparam int unsigned DEF_PAGE_COUNT       = 131072;

  localparam logic [15:0] CONF_MASK = 16'h9F77;
  localparam logic [7:0]  ID_MAKER  = 8'hEC;
  localparam logic [7:0]  ID_DEVICE = 8'h76;
  localparam logic [7:0]  BYTE_ERASED = 8'hFF;

  // command bytes
  localparam logic [7:0] CMD_RESET   = 8'hFF;
  localparam logic [7:0] CMD_READID  = 8'h90;
  localparam logic [7:0] CMD_READ0   = 8'h00;
  localparam logic [7:0] CMD_READ1   = 8'h01;
  localparam logic [7:0] CMD_READOOB = 8'h50;

  // register offsets
  localparam logic [4:0] OFS_CONF = 5'd0;
  localparam logic [4:0] OFS_CMD  = 5'd4;
  localparam logic [4:0] OFS_ADDR = 5'd8;
  localparam logic [4:0] OFS_DATA = 5'd12;
  localparam logic [4:0] OFS_STAT = 5'd16;

  // error codes
  localparam logic [3:0] ERR_OK           = 4'd0;
  localparam logic [3:0] ERR_BAD_ACCESS   = 4'd1;
  localparam logic [3:0] ERR_BAD_CMD      = 4'd2;
  localparam logic [3:0] ERR_ID_ADDR      = 4'd3;
  localparam logic [3:0] ERR_ADDR_NO_READ = 4'd4;
  localparam logic [3:0] ERR_EXTRA_ADDR   = 4'd5;
  localparam logic [3:0] ERR_PAGE_RANGE   = 4'd6;
  localparam logic [3:0] ERR_ID_PAST_END  = 4'd7;
  localparam logic [3:0] ERR_DATA_NO_READ = 4'd8;
  localparam logic [3:0] ERR_ADDR_INCOMPL = 4'd9;
  localparam logic [3:0] ERR_PAST_PAGE    = 4'd10;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_RESET   = 3'd1,
    OP_READID  = 3'd2,
    OP_READ0   = 3'd3,
    OP_READ1   = 3'd4,
    OP_READOOB = 3'd5
  } op_t;

  typedef struct packed {
    logic        kind;
    logic        is_word;
    logic [4:0]  reg_offset;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  error_code;
  } rsp_t;

endpackage
`default_nettype wire

@@ sv/nand_flash_read_interface.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result appears in the output register in the cycle after its request is accepted.
// One transaction per cycle when not stalled; decode and state update are a single
// combinational pass from the request port into the state and output registers.
// The output register keeps taking requests while its result is taken the same cycle.
// Reset (rst, synchronous): no command, all counters, page and conf cleared,
// output register empty.
// ----------------------------------------------------------------------------
// nand_flash_read_interface
// Register-bus front end of a small-page NAND flash controller, read side:
// config, command, address, data and status registers with error reporting.
// ----------------------------------------------------------------------------
module nand_flash_read_interface #(
  parameter int unsigned PAGE_DATA_BYTES  = nfri_pkg::DEF_PAGE_DATA_BYTES,
  parameter int unsigned PAGE_SPARE_BYTES = nfri_pkg::DEF_PAGE_SPARE_BYTES,
  parameter int unsigned PAGE_COUNT       = nfri_pkg::DEF_PAGE_COUNT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire nfri_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output nfri_pkg::rsp_t     rsp
);
  import nfri_pkg::*;

  localparam int unsigned PAGE_TOTAL = PAGE_DATA_BYTES + PAGE_SPARE_BYTES;
  localparam int unsigned POS_W      = $clog2(PAGE_TOTAL + 1);

  // state
  logic [15:0]      conf_reg;
  op_t              current_command;
  logic [1:0]       id_byte_index;
  logic [2:0]       address_cycle_count;
  logic [POS_W-1:0] col_base;
  logic [POS_W-1:0] column_pos;
  logic [23:0]      page_number;

  logic [15:0]      conf_reg_next;
  op_t              current_command_next;
  logic [1:0]       id_byte_index_next;
  logic [2:0]       address_cycle_count_next;
  logic [POS_W-1:0] col_base_next;
  logic [POS_W-1:0] column_pos_next;
  logic [23:0]      page_number_next;

  logic [31:0]      rd;
  logic [3:0]       err;
  logic [7:0]       wb;
  logic             cmd_is_read;
  logic [23:0]      page_full;
  logic [POS_W:0]   where;
  logic             accept;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign wb        = req.write_data[7:0];
  assign cmd_is_read = (current_command == OP_READ0) || (current_command == OP_READ1) ||
                       (current_command == OP_READOOB);
  assign page_full = page_number | {wb, 16'h0000};
  assign where     = {1'b0, col_base} + {1'b0, column_pos};

  always_comb begin
    rd  = '0;
    err = ERR_BAD_ACCESS;
    conf_reg_next            = conf_reg;
    current_command_next     = current_command;
    id_byte_index_next       = id_byte_index;
    address_cycle_count_next = address_cycle_count;
    col_base_next            = col_base;
    column_pos_next          = column_pos;
    page_number_next         = page_number;

    if (req.kind) begin
      if (req.is_word) begin
        if (req.reg_offset == OFS_CONF) begin
          conf_reg_next = req.write_data[15:0] & CONF_MASK;
          err = ERR_OK;
        end
      end else if (req.reg_offset == OFS_CMD) begin
        err = ERR_OK;
        id_byte_index_next       = '0;
        address_cycle_count_next = '0;
        column_pos_next          = '0;
        page_number_next         = '0;
        unique case (wb)
          CMD_RESET:   current_command_next = OP_RESET;
          CMD_READID:  current_command_next = OP_READID;
          CMD_READ0: begin
            current_command_next = OP_READ0;
            col_base_next        = '0;
          end
          CMD_READ1: begin
            current_command_next = OP_READ1;
            col_base_next        = POS_W'(256);
          end
          CMD_READOOB: begin
            current_command_next = OP_READOOB;
            col_base_next        = POS_W'(PAGE_DATA_BYTES);
          end
          default: err = ERR_BAD_CMD;
        endcase
      end else if (req.reg_offset == OFS_ADDR) begin
        if (current_command == OP_READID) begin
          // zero address byte is ignored under read id
          err = (wb != 8'h00) ? ERR_ID_ADDR : ERR_OK;
        end else if (!cmd_is_read) begin
          err = ERR_ADDR_NO_READ;
        end else begin
          err = ERR_OK;
          address_cycle_count_next = address_cycle_count + 3'd1;
          case (address_cycle_count)
            3'd0: column_pos_next  = POS_W'(wb);
            3'd1: page_number_next = {16'h0000, wb};
            3'd2: page_number_next = page_number | {8'h00, wb, 8'h00};
            3'd3: begin
              if ({1'b0, page_full} >= 25'(PAGE_COUNT)) err = ERR_PAGE_RANGE;
              page_number_next = page_full;
            end
            default: err = ERR_EXTRA_ADDR;
          endcase
        end
      end
    end else begin
      if (req.is_word) begin
        if (req.reg_offset == OFS_CONF) begin
          rd  = {16'h0000, conf_reg};
          err = ERR_OK;
        end else if (req.reg_offset == OFS_STAT) begin
          rd  = 32'd1;
          err = ERR_OK;
        end
      end else if (req.reg_offset == OFS_DATA) begin
        if (current_command == OP_READID) begin
          if (id_byte_index >= 2'd2) begin
            err = ERR_ID_PAST_END;
          end else begin
            err = ERR_OK;
            rd  = {24'h0, (id_byte_index == 2'd0) ? ID_MAKER : ID_DEVICE};
            id_byte_index_next = id_byte_index + 2'd1;
          end
        end else if (!cmd_is_read) begin
          err = ERR_DATA_NO_READ;
        end else if (address_cycle_count != 3'd4) begin
          err = ERR_ADDR_INCOMPL;
        end else if (where >= (POS_W+1)'(PAGE_TOTAL)) begin
          err = ERR_PAST_PAGE;
        end else begin
          err = ERR_OK;
          rd  = {24'h0, BYTE_ERASED};
          column_pos_next = column_pos + POS_W'(1);
        end
      end
    end

    if (err != ERR_OK) rd = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_reg            <= '0;
      current_command     <= OP_NONE;
      id_byte_index       <= '0;
      address_cycle_count <= '0;
      col_base            <= '0;
      column_pos          <= '0;
      page_number         <= '0;
      rsp_valid           <= 1'b0;
    end else begin
      // a rejected transaction leaves all state untouched
      if (accept && err == ERR_OK) begin
        conf_reg            <= conf_reg_next;
        current_command     <= current_command_next;
        id_byte_index       <= id_byte_index_next;
        address_cycle_count <= address_cycle_count_next;
        col_base            <= col_base_next;
        column_pos          <= column_pos_next;
        page_number         <= page_number_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_data  <= rd;
      rsp.error_code <= err;
    end
  end

  // assertions
  a_err_zero_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code != ERR_OK |-> rsp.read_data == 32'd0)
    else $error("rejected transaction returned nonzero data");

  a_addr_count: assert property (@(posedge clk) disable iff (rst)
    address_cycle_count <= 3'd4)
    else $error("address cycle count out of range");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    accept && err != ERR_OK |=> $stable(current_command) && $stable(page_number) &&
      $stable(column_pos) && $stable(address_cycle_count) && $stable(conf_reg))
    else $error("rejected transaction changed state");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted transaction produced no result");

  a_id_index: assert property (@(posedge clk) disable iff (rst)
    id_byte_index <= 2'd2)
    else $error("id byte index out of range");

endmodule
`default_nettype wire
